@@ rtl/core/dfsv_pkg.sv @@
// Shared types, constants and helpers for the decaying filter sweep voice.
package dfsv_pkg;

	localparam int PhaseW      = 32;
	localparam int DigitW      = 4;
	localparam int PhaseDigits = PhaseW / DigitW;
	localparam int PhCntW      = $clog2(PhaseDigits);

	localparam int EnvW    = 17;
	localparam int DecayW  = 16;
	localparam int CutW    = 17;
	localparam int GainW   = 16;
	localparam int SampleW = 16;
	localparam int CfgW    = 17;
	localparam int CfgIdxW = 2;

	localparam int McandW  = 18;
	localparam int MplierW = 17;
	localparam int ProdW   = McandW + MplierW - 1;
	localparam int MulCntW = $clog2(MplierW);

	localparam logic [CfgIdxW-1:0] CfgWave  = 2'd0;
	localparam logic [CfgIdxW-1:0] CfgDecay = 2'd1;
	localparam logic [CfgIdxW-1:0] CfgCut   = 2'd2;
	localparam logic [CfgIdxW-1:0] CfgGain  = 2'd3;

	localparam logic [DecayW-1:0] DecayRst = 16'd65000;
	localparam logic [CutW-1:0]   CutRst   = 17'd32768;
	localparam logic [GainW-1:0]  GainRst  = 16'd16384;

	localparam logic [EnvW-1:0] EnvFull = 17'd65536;
	localparam logic [CutW-1:0] CutMin  = 17'd655;
	localparam logic [CutW-1:0] CutMax  = 17'd65536;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ENV,
		ST_FSTART,
		ST_FILT,
		ST_GSTART,
		ST_GAIN,
		ST_OUT
	} voice_st_t;

	typedef struct packed {
		logic                     start;
		logic signed [McandW-1:0] mcand;
		logic [MplierW-1:0]       mplier;
	} mul_req_t;

	function automatic logic signed [SampleW-1:0] sat16(input logic signed [20:0] v);
		logic signed [20:0] hi;
		logic signed [20:0] lo;
		hi = 21'sd32767;
		lo = -21'sd32768;
		if (v > hi)
			sat16 = 16'sh7fff;
		else if (v < lo)
			sat16 = 16'sh8000;
		else
			sat16 = v[SampleW-1:0];
	endfunction

endpackage

@@ rtl/core/decaying_filter_sweep_voice_core.sv @@
// Top level of the decaying filter sweep voice: control sequencer and registers.
//
// One request per sample: a 32-bit phase step and a note trigger; one 16-bit
// signed sample comes back per request. Requests are handled one at a time:
// the next is taken only once the last sample is in the output register. The
// pace is set by the shared bit-serial multiplier, which makes three passes
// per sample (envelope decay, lowpass update, output gain); the phase is
// advanced 4 bits a cycle during the first pass. A finished sample sits in
// the output register, so a new request is taken while it waits. The user must
// write configuration registers only between samples; the block does not enforce it.
module decaying_filter_sweep_voice_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [31:0]                      s_tdata,   // [31:0] phase_step
	input  logic [0:0]                       s_tuser,   // [0] note_trigger
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [15:0]                      m_tdata,   // [15:0] sample_out
	input  logic                             cfg_we,
	input  logic [dfsv_pkg::CfgIdxW-1:0]     cfg_addr,
	input  logic [dfsv_pkg::CfgW-1:0]        cfg_wdata
);
	import dfsv_pkg::*;

	voice_st_t st_q, st_d;

	logic              wave_sel_q;
	logic [DecayW-1:0] decay_q;
	logic [CutW-1:0]   cut_base_q;
	logic [GainW-1:0]  gain_q;

	logic [EnvW-1:0]           env_q;
	logic signed [SampleW-1:0] lp_q;
	logic                      m_tvalid_q;
	logic [SampleW-1:0]        m_tdata_q;

	mul_req_t                mreq;
	logic                    mdone;
	logic signed [ProdW-1:0] mprod;
	logic                    ph_busy;
	logic [PhaseW-1:0]       phase;

	logic                      accept;
	logic [EnvW-1:0]           env_start;
	logic [CutW:0]             cut_sum;
	logic [CutW-1:0]           cut;
	logic signed [SampleW-1:0] raw;
	logic signed [SampleW:0]   diff;
	logic signed [20:0]        lp_sum;
	logic signed [SampleW-1:0] lp_next;
	logic signed [SampleW-1:0] y_sat;
	logic                      env_ld;
	logic                      lp_ld;
	logic                      out_ld;

	dfsv_smul u_smul (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (mreq),
		.done  (mdone),
		.prod  (mprod)
	);

	dfsv_phase u_phase (
		.clk   (clk),
		.arst_n(arst_n),
		.start (accept),
		.step  (s_tdata),
		.busy  (ph_busy),
		.phase (phase)
	);

	assign s_tready = (st_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		env_start = s_tuser[0] ? EnvFull : env_q;

		cut_sum = {1'b0, cut_base_q} + {2'b00, env_q[EnvW-1:1]};
		if (cut_sum > {1'b0, CutMax})
			cut = CutMax;
		else if (cut_sum < {1'b0, CutMin})
			cut = CutMin;
		else
			cut = cut_sum[CutW-1:0];

		if (wave_sel_q)
			raw = phase[PhaseW-1] ? 16'sh8000 : 16'sh7fff;
		else
			raw = {~phase[PhaseW-1], phase[PhaseW-2:PhaseW-SampleW]};
		diff = {raw[SampleW-1], raw} - {lp_q[SampleW-1], lp_q};

		lp_sum  = {{5{lp_q[SampleW-1]}}, lp_q} + {{3{mprod[ProdW-1]}}, mprod[ProdW-1:16]};
		lp_next = sat16(lp_sum);
		y_sat   = sat16({mprod[ProdW-1], mprod[ProdW-1:14]});
	end

	always_comb begin
		st_d   = st_q;
		mreq   = '0;
		env_ld = 1'b0;
		lp_ld  = 1'b0;
		out_ld = 1'b0;
		case (st_q)
			ST_IDLE: begin
				if (accept) begin
					mreq.start  = 1'b1;
					mreq.mcand  = {1'b0, env_start};
					mreq.mplier = {1'b0, decay_q};
					st_d        = ST_ENV;
				end
			end
			ST_ENV: begin
				// phase finishes well before the multiplier
				if (mdone && !ph_busy) begin
					env_ld = 1'b1;
					st_d   = ST_FSTART;
				end
			end
			ST_FSTART: begin
				mreq.start  = 1'b1;
				mreq.mcand  = {diff[SampleW], diff};
				mreq.mplier = cut;
				st_d        = ST_FILT;
			end
			ST_FILT: begin
				if (mdone) begin
					lp_ld = 1'b1;
					st_d  = ST_GSTART;
				end
			end
			ST_GSTART: begin
				mreq.start  = 1'b1;
				mreq.mcand  = {{2{lp_q[SampleW-1]}}, lp_q};
				mreq.mplier = {1'b0, gain_q};
				st_d        = ST_GAIN;
			end
			ST_GAIN: begin
				if (mdone)
					st_d = ST_OUT;
			end
			ST_OUT: begin
				if (!m_tvalid_q || m_tready) begin
					out_ld = 1'b1;
					st_d   = ST_IDLE;
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			st_q <= ST_IDLE;
		else
			st_q <= st_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_sel_q <= 1'b0;
			decay_q    <= DecayRst;
			cut_base_q <= CutRst;
			gain_q     <= GainRst;
		end else if (cfg_we) begin
			case (cfg_addr)
				CfgWave:  wave_sel_q <= cfg_wdata[0];
				CfgDecay: decay_q    <= cfg_wdata[DecayW-1:0];
				CfgCut:   cut_base_q <= cfg_wdata[CutW-1:0];
				CfgGain:  gain_q     <= cfg_wdata[GainW-1:0];
				default:  ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			env_q <= '0;
			lp_q  <= '0;
		end else begin
			if (env_ld)
				env_q <= mprod[EnvW+15:16];
			if (lp_ld)
				lp_q <= lp_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid_q <= 1'b0;
		else if (out_ld)
			m_tvalid_q <= 1'b1;
		else if (m_tready)
			m_tvalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_ld)
			m_tdata_q <= y_sat;
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

@@ rtl/core/dfsv_smul.sv @@
// Bit-serial signed-by-unsigned shift-add multiplier, one multiplier bit per cycle.
module dfsv_smul (
	input  logic                             clk,
	input  logic                             arst_n,
	input  dfsv_pkg::mul_req_t               req,
	output logic                             done,
	output logic signed [dfsv_pkg::ProdW-1:0] prod
);
	import dfsv_pkg::*;

	logic signed [McandW-1:0] mcand_q;
	logic signed [McandW:0]   acc_q;
	logic [MplierW-1:0]       mpl_q;
	logic [MulCntW-1:0]       cnt_q;
	logic                     busy_q;
	logic                     done_q;
	logic signed [McandW:0]   sum;

	always_comb begin
		sum = acc_q + (mpl_q[0] ? {mcand_q[McandW-1], mcand_q} : '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= MulCntW'(MplierW - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			mcand_q <= req.mcand;
			acc_q   <= '0;
			mpl_q   <= req.mplier;
		end else if (busy_q) begin
			acc_q <= {sum[McandW], sum[McandW:1]};
			mpl_q <= {sum[0], mpl_q[MplierW-1:1]};
		end
	end

	assign done = done_q;
	assign prod = {acc_q[McandW-2:0], mpl_q};

endmodule

@@ rtl/core/dfsv_phase.sv @@
// Digit-serial phase accumulator, one 4-bit digit per cycle with a carry flop.
module dfsv_phase (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [dfsv_pkg::PhaseW-1:0]   step,
	output logic                          busy,
	output logic [dfsv_pkg::PhaseW-1:0]   phase
);
	import dfsv_pkg::*;

	logic [PhaseW-1:0] phase_q;
	logic [PhaseW-1:0] step_q;
	logic              carry_q;
	logic [PhCntW-1:0] cnt_q;
	logic              busy_q;
	logic [DigitW:0]   dsum;

	always_comb begin
		dsum = {1'b0, phase_q[DigitW-1:0]} + {1'b0, step_q[DigitW-1:0]} + (DigitW+1)'(carry_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			busy_q  <= 1'b0;
			cnt_q   <= '0;
			carry_q <= 1'b0;
		end else if (start) begin
			busy_q  <= 1'b1;
			cnt_q   <= PhCntW'(PhaseDigits - 1);
			carry_q <= 1'b0;
		end else if (busy_q) begin
			phase_q <= {dsum[DigitW-1:0], phase_q[PhaseW-1:DigitW]};
			carry_q <= dsum[DigitW];
			if (cnt_q == '0)
				busy_q <= 1'b0;
			else
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start)
			step_q <= step;
		else if (busy_q)
			step_q <= {{DigitW{1'b0}}, step_q[PhaseW-1:DigitW]};
	end

	assign busy  = busy_q;
	assign phase = phase_q;

endmodule

@@ bench/decaying_filter_sweep_voice_core_tb.sv @@
// Self-checking bench for the voice core: drives sample requests, predicts each output.
module decaying_filter_sweep_voice_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import dfsv_pkg::*;

	localparam logic WaveSaw    = 1'b0;
	localparam logic WaveSquare = 1'b1;
	localparam int   SettleCycles = 80;
	localparam int   CycleLimit   = 600000;
	localparam int   BurstItems   = 43;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [31:0]         s_tdata = '0;
	logic [0:0]          s_tuser = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [15:0]         m_tdata;
	logic                cfg_we = 1'b0;
	logic [CfgIdxW-1:0]  cfg_addr = '0;
	logic [CfgW-1:0]     cfg_wdata = '0;

	// shadow registers and voice state
	logic                wave_q  = WaveSaw;
	logic [DecayW-1:0]   decay_q = DecayRst;
	logic [CutW-1:0]     cut_q   = CutRst;
	logic [GainW-1:0]    gain_q  = GainRst;
	logic [31:0]         phase_q = '0;
	logic [EnvW-1:0]     env_q   = '0;
	logic signed [15:0]  lp_q    = '0;

	logic [15:0] pending_samples[$];
	int          mismatch_count = 0;
	int          cycle_count = 0;
	int          src_idle_pct = 0;
	int          rcv_stall_pct = 0;

	decaying_filter_sweep_voice_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CycleLimit) begin
			$display("timeout after %0d cycles, %0d samples outstanding", cycle_count,
				pending_samples.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	always @(negedge clk) begin
		m_tready = ($urandom_range(0, 99) >= rcv_stall_pct);
	end

	function automatic logic signed [15:0] clip16(input longint v);
		if (v > 32767)
			return 16'sh7fff;
		if (v < -32768)
			return 16'sh8000;
		return v[15:0];
	endfunction

	// advances the voice by one sample and returns the expected output
	function automatic logic [15:0] voice_next_sample(input logic [31:0] step, input logic trig);
		longint wave;
		longint cut;
		longint delta;
		longint y;
		if (trig)
			env_q = EnvFull;
		phase_q = phase_q + step;
		if (wave_q == WaveSaw)
			wave = longint'(phase_q[31:16]) - 32768;
		else
			wave = phase_q[31] ? -32768 : 32767;
		env_q = EnvW'((longint'(env_q) * longint'(decay_q)) >>> 16);
		cut = longint'(cut_q) + longint'(env_q >> 1);
		if (cut > longint'(CutMax))
			cut = longint'(CutMax);
		if (cut < longint'(CutMin))
			cut = longint'(CutMin);
		delta = (cut * (wave - longint'(lp_q))) >>> 16;
		lp_q = clip16(longint'(lp_q) + delta);
		y = (longint'(lp_q) * longint'(gain_q)) >>> 14;
		return clip16(y);
	endfunction

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		$display("[%0t] MISMATCH: %s", $realtime, msg);
	endtask

	always @(posedge clk) begin : sample_check
		logic [15:0] want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_samples.size() == 0) begin
				report_mismatch($sformatf("sample %h with no request pending", m_tdata));
			end else begin
				want = pending_samples.pop_front();
				if (m_tdata !== want)
					report_mismatch($sformatf("sample_out got %h want %h", m_tdata, want));
			end
		end
	end

	task automatic play_sample(input logic [31:0] step, input logic trig);
		@(negedge clk);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = step;
		s_tuser  = trig;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		pending_samples.push_back(voice_next_sample(step, trig));
	endtask

	// block idle: all samples back, then a pause covering the multiplier passes
	task automatic settle_voice();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (pending_samples.size() != 0)
			@(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] value);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_addr  = idx;
		cfg_wdata = value;
		@(posedge clk);
		case (idx)
			CfgWave:  wave_q  = value[0];
			CfgDecay: decay_q = value[DecayW-1:0];
			CfgCut:   cut_q   = value[CutW-1:0];
			CfgGain:  gain_q  = value[GainW-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic test_defaults();
		play_sample(32'h0000_0000, 1'b0);
		play_sample(32'h8000_0000, 1'b1);
		play_sample(32'hffff_ffff, 1'b0);
		play_sample(32'h0000_0001, 1'b0);
	endtask

	task automatic test_square_full_gain();
		settle_voice();
		write_reg(CfgWave, CfgW'(WaveSquare));
		write_reg(CfgGain, 17'd65535);
		play_sample(32'h4000_0000, 1'b1);
		repeat (4) play_sample(32'h4000_0000, 1'b0);
	endtask

	task automatic test_cut_clamps();
		settle_voice();
		// zero base, no envelope: coefficient held at its floor
		write_reg(CfgCut, 17'd0);
		write_reg(CfgDecay, 17'd0);
		play_sample(32'h2000_0000, 1'b1);
		repeat (2) play_sample(32'hc000_0000, 1'b0);
		settle_voice();
		// oversized base: coefficient capped at one
		write_reg(CfgWave, CfgW'(WaveSaw));
		write_reg(CfgCut, 17'h1ffff);
		write_reg(CfgDecay, 17'd65535);
		write_reg(CfgGain, 17'd0);
		play_sample(32'h7fff_ffff, 1'b1);
		play_sample(32'h0123_4567, 1'b0);
		settle_voice();
		write_reg(CfgGain, 17'd16384);
		play_sample(32'hfedc_ba98, 1'b0);
	endtask

	task automatic test_envelope_sweep();
		settle_voice();
		write_reg(CfgCut, 17'd0);
		write_reg(CfgDecay, 17'd60000);
		write_reg(CfgGain, 17'd32768);
		play_sample(32'h0400_0000, 1'b1);
		repeat (4) play_sample(32'h0400_0000, 1'b0);
		play_sample(32'h0400_0000, 1'b1);
	endtask

	task automatic shuffle_config();
		case ($urandom_range(0, 2))
			0: write_reg(CfgDecay, 17'd0);
			1: write_reg(CfgDecay, 17'd65535);
			default: write_reg(CfgDecay, CfgW'($urandom_range(60000, 65535)));
		endcase
		case ($urandom_range(0, 4))
			0: write_reg(CfgCut, 17'd0);
			1: write_reg(CfgCut, 17'd65536);
			2: write_reg(CfgCut, 17'h1ffff);
			default: write_reg(CfgCut, CfgW'($urandom_range(0, 65536)));
		endcase
		case ($urandom_range(0, 3))
			0: write_reg(CfgGain, 17'd0);
			1: write_reg(CfgGain, 17'd65535);
			2: write_reg(CfgGain, 17'd16384);
			default: write_reg(CfgGain, CfgW'($urandom_range(0, 65535)));
		endcase
		write_reg(CfgWave, CfgW'($urandom_range(0, 1)));
	endtask

	task automatic test_random_voice(input int src_pct, input int rcv_pct);
		logic [31:0] step;
		src_idle_pct  = src_pct;
		rcv_stall_pct = rcv_pct;
		repeat (4) begin
			settle_voice();
			shuffle_config();
			repeat (BurstItems) begin
				case ($urandom_range(0, 3))
					0: step = $urandom;
					1: step = $urandom_range(0, 32'h00ff_ffff);
					2: case ($urandom_range(0, 2))
						0: step = 32'h0000_0000;
						1: step = 32'hffff_ffff;
						default: step = 32'h8000_0000;
					endcase
					default: step = $urandom_range(0, 32'h0fff_ffff);
				endcase
				play_sample(step, $urandom_range(0, 99) < 8);
			end
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_defaults();
		test_square_full_gain();
		test_cut_clamps();
		test_envelope_sweep();
		test_random_voice(0, 0);
		test_random_voice(76, 0);
		test_random_voice(0, 76);
		test_random_voice(37, 37);

		settle_voice();
		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
